@@ design/u16r_pkg.sv @@
// ----------------------------------------------------------------------------
// u16r_pkg: shared types and constants for the 16550 register model
// Function codes, register offsets, status bit values and the per-item
// result record passed from the register file to the output pipeline.
// ----------------------------------------------------------------------------
package u16r_pkg;

	localparam int RX_DEPTH_DEF = 256;

	localparam int FUNC_W = 2;
	localparam int REG_W  = 3;
	localparam int BYTE_W = 8;

	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd2;

	localparam logic [REG_W-1:0] REG_DATA    = 3'd0;
	localparam logic [REG_W-1:0] REG_IER     = 3'd1;
	localparam logic [REG_W-1:0] REG_IIR     = 3'd2;
	localparam logic [REG_W-1:0] REG_LCR     = 3'd3;
	localparam logic [REG_W-1:0] REG_MCR     = 3'd4;
	localparam logic [REG_W-1:0] REG_LSR     = 3'd5;
	localparam logic [REG_W-1:0] REG_MSR     = 3'd6;
	localparam logic [REG_W-1:0] REG_SCRATCH = 3'd7;

	localparam int LCR_DLAB_BIT = 7;
	localparam int IER_RDI_BIT  = 0;
	localparam int IER_THRI_BIT = 1;

	localparam logic [BYTE_W-1:0] IIR_RX_AVAIL = 8'h04;
	localparam logic [BYTE_W-1:0] IIR_THR_EMPTY = 8'h02;
	localparam logic [BYTE_W-1:0] IIR_NO_INT   = 8'h01;
	localparam logic [BYTE_W-1:0] LSR_TX_IDLE  = 8'h60;
	localparam logic [BYTE_W-1:0] LSR_DR       = 8'h01;
	localparam logic [BYTE_W-1:0] MSR_FIXED    = 8'hB0;
	localparam logic [BYTE_W-1:0] DLL_RESET    = 8'h01;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              irq;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              dropped;
		logic              pop;
	} res_t;

endpackage

@@ design/u16r_ram.sv @@
// ----------------------------------------------------------------------------
// u16r_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module u16r_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/u16r_ctrl.sv @@
// ----------------------------------------------------------------------------
// u16r_ctrl: register file and receive ring pointers
// Decodes one item per cycle while fire is high, updates IER/LCR/MCR/scratch/divisor/THRE
// state and the ring pointers, and drives the ring RAM ports.
// ----------------------------------------------------------------------------
module u16r_ctrl #(
	parameter int RX_DEPTH = u16r_pkg::RX_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [u16r_pkg::FUNC_W-1:0] func,
	input  logic [u16r_pkg::REG_W-1:0]  reg_req,
	input  logic [u16r_pkg::BYTE_W-1:0] write_data,
	input  logic [u16r_pkg::BYTE_W-1:0] rx_data,
	output u16r_pkg::res_t              res,
	output logic                        ram_we,
	output logic [$clog2(RX_DEPTH)-1:0] ram_waddr,
	output logic [u16r_pkg::BYTE_W-1:0] ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(RX_DEPTH)-1:0] ram_raddr
);

	import u16r_pkg::*;

	localparam int PW = $clog2(RX_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(RX_DEPTH - 1);

	logic [BYTE_W-1:0] ier_q, lcr_q, mcr_q, scr_q, dll_q, dlm_q;
	logic              thre_q;
	logic [PW-1:0]     head_q, tail_q;

	logic [BYTE_W-1:0] ier_d, lcr_d, mcr_d, scr_d, dll_d, dlm_d;
	logic              thre_d;
	logic [PW-1:0]     head_d, tail_d;
	logic [PW-1:0]     head_nx, tail_nx;
	logic              dlab, empty, full, push;

	assign dlab    = lcr_q[LCR_DLAB_BIT];
	assign empty   = (head_q == tail_q);
	assign head_nx = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign full    = (head_nx == tail_q);

	always_comb begin
		res    = '0;
		push   = 1'b0;
		ier_d  = ier_q;
		lcr_d  = lcr_q;
		mcr_d  = mcr_q;
		scr_d  = scr_q;
		dll_d  = dll_q;
		dlm_d  = dlm_q;
		thre_d = thre_q;
		head_d = head_q;
		tail_d = tail_q;
		case (func)
			FUNC_READ: begin
				case (reg_req)
					REG_DATA: begin
						if (dlab) begin
							res.read_data = dll_q;
						end else if (!empty) begin
							res.pop = 1'b1;
							tail_d  = tail_nx;
						end
					end
					REG_IER: res.read_data = dlab ? dlm_q : ier_q;
					REG_IIR: begin
						if (ier_q[IER_RDI_BIT] && !empty) begin
							res.read_data = IIR_RX_AVAIL;
						end else if (ier_q[IER_THRI_BIT] && thre_q) begin
							res.read_data = IIR_THR_EMPTY;
							thre_d        = 1'b0;
						end else begin
							res.read_data = IIR_NO_INT;
						end
					end
					REG_LCR: res.read_data = lcr_q;
					REG_MCR: res.read_data = mcr_q;
					REG_LSR: res.read_data = empty ? LSR_TX_IDLE : (LSR_TX_IDLE | LSR_DR);
					REG_MSR: res.read_data = MSR_FIXED;
					default: res.read_data = scr_q;
				endcase
			end
			FUNC_WRITE: begin
				case (reg_req)
					REG_DATA: begin
						if (dlab) begin
							dll_d = write_data;
						end else begin
							res.tx_valid = 1'b1;
							res.tx_byte  = write_data;
							if (ier_q[IER_THRI_BIT]) begin
								thre_d  = 1'b1;
								res.irq = 1'b1;
							end
						end
					end
					REG_IER: begin
						if (dlab) begin
							dlm_d = write_data;
						end else begin
							ier_d = write_data;
							if (write_data[IER_THRI_BIT] && !ier_q[IER_THRI_BIT]) begin
								thre_d  = 1'b1;
								res.irq = 1'b1;
							end
							if (write_data[IER_RDI_BIT] && !empty) begin
								res.irq = 1'b1;
							end
						end
					end
					REG_LCR:     lcr_d = write_data;
					REG_MCR:     mcr_d = write_data;
					REG_SCRATCH: scr_d = write_data;
					default: ;
				endcase
			end
			FUNC_RX: begin
				if (full) begin
					res.dropped = 1'b1;
				end else begin
					push   = 1'b1;
					head_d = head_nx;
				end
				res.irq = ier_q[IER_RDI_BIT];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q  <= '0;
			lcr_q  <= '0;
			mcr_q  <= '0;
			scr_q  <= '0;
			dll_q  <= DLL_RESET;
			dlm_q  <= '0;
			thre_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
		end else if (fire) begin
			ier_q  <= ier_d;
			lcr_q  <= lcr_d;
			mcr_q  <= mcr_d;
			scr_q  <= scr_d;
			dll_q  <= dll_d;
			dlm_q  <= dlm_d;
			thre_q <= thre_d;
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	assign ram_we    = fire && push;
	assign ram_waddr = head_q;
	assign ram_wdata = rx_data;
	assign ram_re    = fire && res.pop;
	assign ram_raddr = tail_q;

endmodule

@@ design/uart_16550_register_model_core.sv @@
// ----------------------------------------------------------------------------
// uart_16550_register_model_core: 16550 register file with receive ring
// Input channel (in_valid/in_ready) carries one item: a register read, a
// register write or a byte received from the host. Output channel
// (out_valid/out_ready) returns exactly one result per item, in order.
// An item passes through the first stage register and then the output
// register before out_valid rises; throughput is one item per cycle
// while the output is not stalled. The receive ring sits in a RAM of
// RX_DEPTH bytes (one slot kept free); a data-register read pops it through
// the RAM read port, whose registered read data sets the extra pipeline stage.
// Reset clears all UART registers and the ring pointers (DLL resets to 1); the
// ring contents need no clearing, so items are taken right after reset.
// When the receiver stalls, the output register holds its result and one
// more item waits in the first stage; in_ready then drops until the
// output register is taken.
// ----------------------------------------------------------------------------
module uart_16550_register_model_core #(
	parameter int RX_DEPTH = u16r_pkg::RX_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [u16r_pkg::FUNC_W-1:0] func,
	input  logic [u16r_pkg::REG_W-1:0]  reg_req,
	input  logic [u16r_pkg::BYTE_W-1:0] write_data,
	input  logic [u16r_pkg::BYTE_W-1:0] rx_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [u16r_pkg::BYTE_W-1:0] read_data,
	output logic                        irq_raise,
	output logic                        tx_valid,
	output logic [u16r_pkg::BYTE_W-1:0] tx_byte,
	output logic                        rx_dropped
);

	import u16r_pkg::*;

	localparam int PW = $clog2(RX_DEPTH);

	res_t              res;
	res_t              res_s1;
	logic              valid_s1;
	logic              fire, adv_s1;
	logic              ram_we, ram_re;
	logic [PW-1:0]     ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	logic              out_valid_q;
	logic [BYTE_W-1:0] read_data_q, tx_byte_q;
	logic              irq_q, tx_valid_q, dropped_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign fire     = in_valid && in_ready;

	u16r_ctrl #(
		.RX_DEPTH (RX_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (func),
		.reg_req    (reg_req),
		.write_data (write_data),
		.rx_data    (rx_data),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr)
	);

	u16r_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RX_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_q <= res_s1.pop ? ram_rdata : res_s1.read_data;
			irq_q       <= res_s1.irq;
			tx_valid_q  <= res_s1.tx_valid;
			tx_byte_q   <= res_s1.tx_byte;
			dropped_q   <= res_s1.dropped;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign irq_raise  = irq_q;
	assign tx_valid   = tx_valid_q;
	assign tx_byte    = tx_byte_q;
	assign rx_dropped = dropped_q;

endmodule

@@ design/u16r_chk.sv @@
// ----------------------------------------------------------------------------
// u16r_chk: port-level checks for the 16550 register model
// Watches the top-level ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module u16r_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [u16r_pkg::FUNC_W-1:0] func,
	input logic [u16r_pkg::REG_W-1:0]  reg_req,
	input logic [u16r_pkg::BYTE_W-1:0] write_data,
	input logic [u16r_pkg::BYTE_W-1:0] rx_data,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [u16r_pkg::BYTE_W-1:0] read_data,
	input logic                        irq_raise,
	input logic                        tx_valid,
	input logic [u16r_pkg::BYTE_W-1:0] tx_byte,
	input logic                        rx_dropped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_byte))
		else $error("stalled result changed");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_tx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> read_data == '0 && !rx_dropped)
		else $error("transmit transfer carries read data or drop");

	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == '0)
		else $error("tx_byte set without tx_valid");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_dropped |-> read_data == '0)
		else $error("dropped byte transfer carries read data");

endmodule

bind uart_16550_register_model_core u16r_chk u_chk (.*);
